// ===== design/csc_pkg.sv =====
package csc_pkg;

  // number of table entries, and the deepest chain supported
  localparam int unsigned MAX_ITERATIONS = 13;

  // datapath widths
  localparam int unsigned XY_W    = 18;
  localparam int unsigned Z_W     = 16;
  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned FOLD_W  = 14;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned ATAN_W  = 13;

  // gain-compensated start value of x in Q15
  localparam logic signed [XY_W-1:0] X_INIT = 18'sd19898;

  // quadrant codes, taken from the top two angle bits
  localparam logic [1:0] QUAD_1 = 2'd0;
  localparam logic [1:0] QUAD_2 = 2'd1;
  localparam logic [1:0] QUAD_3 = 2'd2;
  localparam logic [1:0] QUAD_4 = 2'd3;

  // arctangent of 2^-i, 8192 codes per quarter turn
  localparam logic [ATAN_W-1:0] ATAN_TABLE [MAX_ITERATIONS] = '{
    13'd4096, 13'd2418, 13'd1277, 13'd648, 13'd326, 13'd163, 13'd81,
    13'd41, 13'd20, 13'd10, 13'd5, 13'd3, 13'd1
  };

  // payload handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [FOLD_W-1:0]      angle;
    logic [1:0]             quad;
  } cell_data_t;

endpackage

// ===== design/cordic_sine_cosine_unit.sv =====
// Rotation-mode CORDIC sine/cosine. Takes one 15-bit angle per clock (0..32767 is a
// full turn) and returns sine and cosine together as Q15 values saturated to 16 bits.
// The angle is folded into the first quadrant in an input register, runs through a
// chain of ITERATIONS rotation cells, one register each, and gets its quadrant sign
// fix and saturation in the output register. The whole chain advances together
// whenever the output beat is taken or the output is empty, so with the output side
// ready the unit sustains one beat per clock.
module cordic_sine_cosine_unit #(
  parameter int unsigned ITERATIONS = csc_pkg::MAX_ITERATIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [14:0] angle, [15] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] sine, [31:16] cosine
);

  localparam int unsigned SUM_W = csc_pkg::XY_W + 1;

  logic                          en;
  logic [csc_pkg::ANGLE_W-1:0]   angle_in;
  logic [csc_pkg::ANGLE_W-1:0]   folded_wide;
  logic [1:0]                    quad_in;
  logic                          stage_valid [ITERATIONS+1];
  csc_pkg::cell_data_t           stage_data  [ITERATIONS+1];
  csc_pkg::cell_data_t           fold_next;
  csc_pkg::cell_data_t           last_data;
  logic signed [SUM_W-1:0]       sine_wide;
  logic signed [SUM_W-1:0]       cosine_wide;
  logic signed [csc_pkg::OUT_W-1:0] sine;
  logic signed [csc_pkg::OUT_W-1:0] cosine;

  function automatic logic signed [csc_pkg::OUT_W-1:0] sat16(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [csc_pkg::OUT_W-1:0] r;
    if (v > signed'(SUM_W'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -signed'(SUM_W'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[csc_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  // the chain moves when the output register is free or being drained
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // quadrant fold into 0..8192
  always_comb begin
    angle_in = s_axis_tdata[csc_pkg::ANGLE_W-1:0];
    quad_in  = angle_in[csc_pkg::ANGLE_W-1:csc_pkg::ANGLE_W-2];
    case (quad_in)
      csc_pkg::QUAD_1: folded_wide = angle_in;
      csc_pkg::QUAD_2: folded_wide = 15'd16384 - angle_in;
      csc_pkg::QUAD_3: folded_wide = angle_in - 15'd16384;
      csc_pkg::QUAD_4: folded_wide = 15'd32767 - angle_in;
      default:         folded_wide = angle_in;
    endcase
    fold_next.x     = csc_pkg::X_INIT;
    fold_next.y     = '0;
    fold_next.z     = '0;
    fold_next.angle = folded_wide[csc_pkg::FOLD_W-1:0];
    fold_next.quad  = quad_in;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (en) begin
      stage_valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_data[0] <= fold_next;
    end
  end

  // chain of rotation cells
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    csc_cell #(
      .STEP (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (stage_valid[k]),
      .data_in   (stage_data[k]),
      .valid_out (stage_valid[k+1]),
      .data_out  (stage_data[k+1])
    );
  end

  // quadrant sign fix; saturation follows in the output register
  always_comb begin
    last_data   = stage_data[ITERATIONS];
    sine_wide   = SUM_W'(last_data.y);
    cosine_wide = SUM_W'(last_data.x);
    if (last_data.quad == csc_pkg::QUAD_3 || last_data.quad == csc_pkg::QUAD_4) begin
      sine_wide = -sine_wide;
    end
    if (last_data.quad == csc_pkg::QUAD_2 || last_data.quad == csc_pkg::QUAD_3) begin
      cosine_wide = -cosine_wide;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= stage_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine   <= sat16(sine_wide);
      cosine <= sat16(cosine_wide);
    end
  end

  assign m_axis_tdata = {cosine, sine};

  // an accepted beat reaches the first cell on the next edge
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> stage_valid[0])
    else $error("accepted beat lost at input register");

  // a beat leaving the last cell lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    stage_valid[ITERATIONS] && en |=> m_axis_tvalid)
    else $error("beat lost at output register");

  // folded angle stays within one quadrant
  assert property (@(posedge clk) disable iff (rst)
    stage_valid[0] |-> stage_data[0].angle <= 14'd8192)
    else $error("quadrant fold out of range");

  // accumulated angle stays within -9000..17000
  assert property (@(posedge clk) disable iff (rst)
    stage_valid[ITERATIONS] |->
      (stage_data[ITERATIONS].z <= 16'sd17000 && stage_data[ITERATIONS].z >= -16'sd9000))
    else $error("angle accumulator out of range");

endmodule

// ===== design/csc_cell.sv =====
module csc_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  csc_pkg::cell_data_t data_in,
  output logic                valid_out,
  output csc_pkg::cell_data_t data_out
);

  logic signed [csc_pkg::XY_W-1:0] x_shift;
  logic signed [csc_pkg::XY_W-1:0] y_shift;
  logic signed [csc_pkg::Z_W-1:0]  target;
  logic signed [csc_pkg::Z_W-1:0]  step_angle;
  logic                            forward;
  csc_pkg::cell_data_t             data_next;

  // one rotation step: shifted add/subtract and arctangent update
  always_comb begin
    x_shift    = data_in.x >>> STEP;
    y_shift    = data_in.y >>> STEP;
    target     = signed'({{(csc_pkg::Z_W-csc_pkg::FOLD_W){1'b0}}, data_in.angle});
    step_angle = signed'({{(csc_pkg::Z_W-csc_pkg::ATAN_W){1'b0}},
                          csc_pkg::ATAN_TABLE[STEP]});
    forward    = data_in.z < target;
    data_next  = data_in;
    if (forward) begin
      data_next.x = data_in.x - y_shift;
      data_next.y = data_in.y + x_shift;
      data_next.z = data_in.z + step_angle;
    end else begin
      data_next.x = data_in.x + y_shift;
      data_next.y = data_in.y - x_shift;
      data_next.z = data_in.z - step_angle;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule
